// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/sgn_pkg.sv
// ----------------------------------------------------------------------------
// sgn_pkg
// Shared constants and types of the seeded 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package sgn_pkg;

    localparam int NUM_STAGES    = 9;
    localparam int CORNERS       = 4;
    localparam int FRAC_BITS_DEF = 16;

    // lattice hash mixer constants
    localparam logic [31:0] K_HX   = 32'h8da6b343;
    localparam logic [31:0] K_HZ   = 32'hd8163841;
    localparam logic [31:0] K_SEED = 32'h9e3779b9;
    localparam logic [31:0] K_XOR  = 32'hcb1ab31f;
    localparam logic [31:0] K_M1   = 32'h7feb352d;
    localparam logic [31:0] K_M2   = 32'h846ca68b;

    // 0.70710678 in Q16
    localparam logic [16:0] DIAG_Q16 = 17'd46341;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    typedef enum logic [2:0] {
        GRAD_PX  = 3'd0,
        GRAD_NX  = 3'd1,
        GRAD_PZ  = 3'd2,
        GRAD_NZ  = 3'd3,
        GRAD_DPP = 3'd4,
        GRAD_DNP = 3'd5,
        GRAD_DPN = 3'd6,
        GRAD_DNN = 3'd7
    } grad_t;

    // corner order: bit 0 selects x+1, bit 1 selects z+1
    typedef logic [CORNERS-1:0][2:0] grad_quad_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

// File: rtl/sgn_hash.sv
// ----------------------------------------------------------------------------
// sgn_hash
// Seeded lattice hash of the four cell corners, three multiply stages.
// ----------------------------------------------------------------------------
module sgn_hash
    import sgn_pkg::*;
(
    input  logic        aclk,
    input  pipe_ctl_t   ctl,
    input  logic [31:0] seed,
    input  logic [31:0] cell_x,
    input  logic [31:0] cell_z,
    output grad_quad_t  grad
);

    logic [31:0] mx_reg, mz_reg, ms_reg;
    logic [31:0] mx_next, mz_next, ms_next;
    logic [CORNERS-1:0][31:0] p_reg, p_next;
    logic [CORNERS-1:0][31:0] q_reg, q_next;

    always_comb begin
        logic [31:0] hx, hz, h0, h1, h2;
        mx_next = 32'(cell_x * K_HX);
        mz_next = 32'(cell_z * K_HZ);
        ms_next = 32'(seed * K_SEED);
        for (int c = 0; c < CORNERS; c++) begin
            // (cell+1)*K == cell*K + K modulo 2^32
            hx = c[0] ? 32'(mx_reg + K_HX) : mx_reg;
            hz = c[1] ? 32'(mz_reg + K_HZ) : mz_reg;
            h0 = hx ^ hz ^ ms_reg ^ K_XOR;
            h1 = h0 ^ (h0 >> 16);
            p_next[c] = 32'(h1 * K_M1);
            h2 = p_reg[c] ^ (p_reg[c] >> 15);
            q_next[c] = 32'(h2 * K_M2);
            grad[c] = q_reg[c][2:0] ^ q_reg[c][18:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            mx_reg <= mx_next;
            mz_reg <= mz_next;
            ms_reg <= ms_next;
        end
        if (ctl.load[1]) begin
            p_reg <= p_next;
        end
        if (ctl.load[2]) begin
            q_reg <= q_next;
        end
    end

endmodule

// File: rtl/sgn_fade.sv
// ----------------------------------------------------------------------------
// sgn_fade
// Quintic fade 6t^5-15t^4+10t^3 in Q16, one power per stage, clamped.
// ----------------------------------------------------------------------------
module sgn_fade
    import sgn_pkg::*;
(
    input  logic        aclk,
    input  pipe_ctl_t   ctl,
    input  logic [15:0] t_in,
    output logic [16:0] fade
);

    logic [15:0] t0_reg, t1_reg, t2_reg;
    logic [15:0] pw2_reg, pw3a_reg, pw3b_reg, pw3c_reg, pw4_reg, pw4b_reg, pw5_reg;
    logic [15:0] pw2_next, pw3_next, pw4_next, pw5_next;
    logic [16:0] fade_reg, fade_next;

    always_comb begin
        logic [31:0] m2, m3, m4, m5;
        logic signed [23:0] sum;
        m2 = t_in * t_in;
        m3 = pw2_reg * t0_reg;
        m4 = pw3a_reg * t1_reg;
        m5 = pw4_reg * t2_reg;
        pw2_next = m2[31:16];
        pw3_next = m3[31:16];
        pw4_next = m4[31:16];
        pw5_next = m5[31:16];
        sum = 24'(6 * $signed({8'd0, pw5_reg})) + 24'(10 * $signed({8'd0, pw3c_reg}))
            - 24'(15 * $signed({8'd0, pw4b_reg}));
        if (sum < 0) begin
            fade_next = '0;
        end else if (sum > $signed({7'd0, ONE_Q16})) begin
            fade_next = ONE_Q16;
        end else begin
            fade_next = sum[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            t0_reg  <= t_in;
            pw2_reg <= pw2_next;
        end
        if (ctl.load[1]) begin
            t1_reg   <= t0_reg;
            pw3a_reg <= pw3_next;
        end
        if (ctl.load[2]) begin
            t2_reg   <= t1_reg;
            pw3b_reg <= pw3a_reg;
            pw4_reg  <= pw4_next;
        end
        if (ctl.load[3]) begin
            pw3c_reg <= pw3b_reg;
            pw4b_reg <= pw4_reg;
            pw5_reg  <= pw5_next;
        end
        if (ctl.load[4]) begin
            fade_reg <= fade_next;
        end
    end

    // t3 and t4 ride along with t5 through the stage that forms t5
    assign fade = fade_reg;

endmodule

// File: rtl/sgn_blend.sv
// ----------------------------------------------------------------------------
// sgn_blend
// Corner dot products, diagonal scaling, two lerp levels and Q2.14 output.
// ----------------------------------------------------------------------------
module sgn_blend
    import sgn_pkg::*;
(
    input  logic         aclk,
    input  pipe_ctl_t    ctl,
    input  logic [15:0]  off_x,
    input  logic [15:0]  off_z,
    input  grad_quad_t   grad,
    input  logic [16:0]  fade_x,
    input  logic [16:0]  fade_z,
    output logic [15:0]  noise_value
);

    logic [2:0][15:0] dx_reg, dz_reg;

    logic signed [CORNERS-1:0][18:0] v_reg, v_next;
    logic [CORNERS-1:0]              diag_reg, diag_next;
    logic signed [CORNERS-1:0][17:0] n_reg, n_next;

    logic signed [36:0] plo_reg, phi_reg, plo_next, phi_next;
    logic signed [17:0] n00_reg, n01_reg;
    logic [16:0]        fz5_reg, fz6_reg;
    logic signed [18:0] lo6_reg, hi6_reg, lo6_next, hi6_next;
    logic signed [37:0] p7_reg, p7_next;
    logic signed [18:0] lo7_reg;
    logic [15:0]        out_reg, out_next;

    always_comb begin
        logic signed [18:0] ex, ez, dlo, dhi;
        logic signed [36:0] dprod;
        logic signed [19:0] d2;
        logic signed [20:0] rr;
        logic signed [18:0] qv;
        for (int c = 0; c < CORNERS; c++) begin
            ex = $signed({3'd0, dx_reg[2]}) - (c[0] ? 19'sd65536 : 19'sd0);
            ez = $signed({3'd0, dz_reg[2]}) - (c[1] ? 19'sd65536 : 19'sd0);
            diag_next[c] = 1'b1;
            case (grad_t'(grad[c]))
                GRAD_PX: begin
                    v_next[c] = ex;
                    diag_next[c] = 1'b0;
                end
                GRAD_NX: begin
                    v_next[c] = -ex;
                    diag_next[c] = 1'b0;
                end
                GRAD_PZ: begin
                    v_next[c] = ez;
                    diag_next[c] = 1'b0;
                end
                GRAD_NZ: begin
                    v_next[c] = -ez;
                    diag_next[c] = 1'b0;
                end
                GRAD_DPP: v_next[c] = ex + ez;
                GRAD_DNP: v_next[c] = ez - ex;
                GRAD_DPN: v_next[c] = ex - ez;
                default:  v_next[c] = -ex - ez;
            endcase
            // arithmetic shift of the product is the floored Q16 scale
            dprod = 37'($signed(v_reg[c]) * $signed({1'b0, DIAG_Q16}));
            n_next[c] = diag_reg[c] ? dprod[33:16] : v_reg[c][17:0];
        end

        dlo = 19'($signed(n_reg[1])) - 19'($signed(n_reg[0]));
        dhi = 19'($signed(n_reg[3])) - 19'($signed(n_reg[2]));
        plo_next = 37'(dlo * $signed({1'b0, fade_x}));
        phi_next = 37'(dhi * $signed({1'b0, fade_x}));

        lo6_next = 19'(n00_reg) + plo_reg[34:16];
        hi6_next = 19'(n01_reg) + phi_reg[34:16];

        d2 = 20'(hi6_reg) - 20'(lo6_reg);
        p7_next = 38'(d2 * $signed({1'b0, fz6_reg}));

        // round half up to Q2.14, then saturate
        rr = 21'(lo7_reg) + 21'($signed(p7_reg[35:16])) + 21'sd2;
        qv = rr[20:2];
        if (qv > 19'sd32767) begin
            out_next = 16'h7fff;
        end else if (qv < -19'sd32768) begin
            out_next = 16'h8000;
        end else begin
            out_next = qv[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            dx_reg[0] <= off_x;
            dz_reg[0] <= off_z;
        end
        if (ctl.load[1]) begin
            dx_reg[1] <= dx_reg[0];
            dz_reg[1] <= dz_reg[0];
        end
        if (ctl.load[2]) begin
            dx_reg[2] <= dx_reg[1];
            dz_reg[2] <= dz_reg[1];
        end
        if (ctl.load[3]) begin
            v_reg    <= v_next;
            diag_reg <= diag_next;
        end
        if (ctl.load[4]) begin
            n_reg <= n_next;
        end
        if (ctl.load[5]) begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            n00_reg <= n_reg[0];
            n01_reg <= n_reg[2];
            fz5_reg <= fade_z;
        end
        if (ctl.load[6]) begin
            lo6_reg <= lo6_next;
            hi6_reg <= hi6_next;
            fz6_reg <= fz5_reg;
        end
        if (ctl.load[7]) begin
            p7_reg  <= p7_next;
            lo7_reg <= lo6_reg;
        end
        if (ctl.load[8]) begin
            out_reg <= out_next;
        end
    end

    assign noise_value = out_reg;

endmodule

// File: rtl/seeded_gradient_noise_2d_top.sv
// Throughput: one point per cycle; the nine-stage pipeline (hash multiplies,
// fade powers, lerp multiplies) takes a new point whenever its first stage frees.
// Each stage holds its data on a stall, so bubbles collapse behind a stalled output.
// Reset: aresetn (synchronous, active low) clears all stage valid bits and the seed.
// ----------------------------------------------------------------------------
// seeded_gradient_noise_2d_top
// Seeded 2D gradient noise of a Q16.16 point, output in Q2.14.
// ----------------------------------------------------------------------------
module seeded_gradient_noise_2d_top
    import sgn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // seed register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input point
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] x_coord, [63:32] z_coord
    // noise result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] noise_value
);

`include "assert_macros.svh"

    logic [31:0] seed_reg;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] ready;
    pipe_ctl_t ctl;

    logic signed [31:0] x_coord, z_coord;
    logic [31:0] cell_x, cell_z;
    logic [15:0] off_x, off_z;
    grad_quad_t grad;
    logic [16:0] fade_x, fade_z;
    logic [15:0] noise_value;

    assign x_coord = $signed(s_tdata[31:0]);
    assign z_coord = $signed(s_tdata[63:32]);

    assign cell_x = 32'(x_coord >>> FRAC_BITS);
    assign cell_z = 32'(z_coord >>> FRAC_BITS);

    generate
        if (FRAC_BITS >= 16) begin : g_trunc
            assign off_x = x_coord[FRAC_BITS-1 -: 16];
            assign off_z = z_coord[FRAC_BITS-1 -: 16];
        end else begin : g_fill
            assign off_x = {x_coord[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
            assign off_z = {z_coord[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        end
    endgenerate

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            seed_reg <= cfg_data;
        end
    end

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        ready[NUM_STAGES-1] = m_tready || !valid_reg[NUM_STAGES-1];
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            ready[i] = ready[i+1] || !valid_reg[i];
        end
        valid_next[0] = ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
        ctl.load = ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = noise_value;

    sgn_hash u_hash (
        .aclk   (aclk),
        .ctl    (ctl),
        .seed   (seed_reg),
        .cell_x (cell_x),
        .cell_z (cell_z),
        .grad   (grad)
    );

    sgn_fade u_fade_x (
        .aclk (aclk),
        .ctl  (ctl),
        .t_in (off_x),
        .fade (fade_x)
    );

    sgn_fade u_fade_z (
        .aclk (aclk),
        .ctl  (ctl),
        .t_in (off_z),
        .fade (fade_z)
    );

    sgn_blend u_blend (
        .aclk        (aclk),
        .ctl         (ctl),
        .off_x       (off_x),
        .off_z       (off_z),
        .grad        (grad),
        .fade_x      (fade_x),
        .fade_z      (fade_z),
        .noise_value (noise_value)
    );

    // input backpressure only when every stage is full and the output stalls
    `ASSERT_IMPLIES(a_full_stall, aclk, aresetn, !s_tready,
                    (&valid_reg) && !m_tready)
    `ASSERT_NEXT(a_enter_first, aclk, aresetn, s_tvalid && s_tready, valid_reg[0])
    `ASSERT_NEXT(a_drain, aclk, aresetn,
                 m_tvalid && m_tready && !valid_reg[NUM_STAGES-2], !m_tvalid)

endmodule
